### src/host_name_syntax_check_top_defines.svh
// Assertion macros for the host name syntax checker.
// Used by host_name_syntax_check_top; no other dependencies.
`ifndef HOST_NAME_SYNTAX_CHECK_TOP_DEFINES_SVH
`define HOST_NAME_SYNTAX_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HNSC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HNSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/hnsc_pkg.sv
// Shared constants, types and helpers of the host name syntax checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hnsc_pkg;

   localparam int LEVEL_MAX = 255;
   localparam int LEVEL_W   = $clog2(LEVEL_MAX + 1);

   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_DASH       = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   localparam logic [LEVEL_W:0] MIN_TAIL_LABELS = (LEVEL_W + 1)'(2);

   typedef struct packed {
      logic               label_starting;
      logic               prev_alnum;
      logic [LEVEL_W-1:0] label_count;
      logic [LEVEL_W-1:0] underscore_label;
      logic               found_error;
   } hnsc_state_type;

   localparam hnsc_state_type STATE_RESET = '{
      label_starting:   1'b1,
      prev_alnum:       1'b0,
      label_count:      '0,
      underscore_label: '0,
      found_error:      1'b0
   };

   function automatic logic is_alnum(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

### src/hnsc_step.sv
// Next-state and verdict logic for one request of the syntax checker.
// Depends on hnsc_pkg for the state type and byte constants.
`timescale 1ns / 1ps

module hnsc_step
   import hnsc_pkg::*;
(
   input  hnsc_state_type cur_state,
   input  logic [7:0]     host_byte,
   input  logic           has_byte,
   input  logic           end_of_host,
   output hnsc_state_type nxt_state,
   output logic           verdict
);

   hnsc_state_type upd;
   logic           alnum;
   logic [LEVEL_W:0] tail_limit;

   always_comb begin
      upd   = cur_state;
      alnum = is_alnum(host_byte);
      if (has_byte && !cur_state.found_error) begin
         if (host_byte == CHAR_DOT) begin
            if (!cur_state.prev_alnum || cur_state.label_starting) begin
               upd.found_error = 1'b1;
            end else begin
               upd.label_starting = 1'b1;
            end
         end else begin
            upd.prev_alnum = alnum;
            if (cur_state.label_starting) begin
               if (!alnum) begin
                  upd.found_error = 1'b1;
               end else begin
                  upd.label_starting = 1'b0;
                  if (cur_state.label_count < LEVEL_W'(LEVEL_MAX)) begin
                     upd.label_count = cur_state.label_count + LEVEL_W'(1);
                  end
               end
            end else if (alnum || host_byte == CHAR_DASH) begin
               upd.found_error = cur_state.found_error;
            end else if (host_byte == CHAR_UNDERSCORE) begin
               upd.underscore_label = cur_state.label_count;
            end else begin
               upd.found_error = 1'b1;
            end
         end
      end
   end

   assign tail_limit = {1'b0, upd.underscore_label} + MIN_TAIL_LABELS;

   assign verdict = upd.found_error ||
                    ((upd.underscore_label != '0) &&
                     ({1'b0, upd.label_count} < tail_limit));

   assign nxt_state = end_of_host ? STATE_RESET : upd;

endmodule

### src/host_name_syntax_check_top.sv
// Host name syntax checker: request stage register, state, result register.
// Depends on hnsc_pkg, hnsc_step and host_name_syntax_check_top_defines.svh.
//
// Usage:
//  - Requests carry one byte of a host name (req_host_byte, req_has_byte) and
//    req_end_of_host on the last one. An end request with no byte closes an
//    empty or already complete host.
//  - Only end requests produce a response: rsp_verdict is 0 for a good host
//    and 1 for a bad one. The checker then returns to its start state.
//  - Throughput: one request per cycle while no end request waits on a held
//    response; the state update in hnsc_step is combinational.
//  - Path: a taken request is checked from the stage register, and an end
//    request's verdict is then captured in the result register.
//  - Stall: a held response blocks an end request in the stage; byte requests
//    ahead pass; later ones wait. req_ready follows rsp_ready combinationally.
//  - Reset (synchronous, active high): empties both registers and restores
//    the start state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "host_name_syntax_check_top_defines.svh"

module host_name_syntax_check_top
   import hnsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_host_byte,
   input  logic       req_has_byte,
   input  logic       req_end_of_host,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_verdict
);

   logic           stg_valid_ff, stg_valid_in;
   logic [7:0]     stg_byte_ff;
   logic           stg_has_ff;
   logic           stg_end_ff;
   hnsc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_verdict_ff;
   logic           step_verdict;
   logic           out_free;
   logic           stg_advance;
   logic           req_take;

   hnsc_step u_step (
      .cur_state   (state_ff),
      .host_byte   (stg_byte_ff),
      .has_byte    (stg_has_ff),
      .end_of_host (stg_end_ff),
      .nxt_state   (state_in),
      .verdict     (step_verdict)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign stg_advance  = stg_valid_ff && (!stg_end_ff || out_free);
   assign req_ready    = !stg_valid_ff || stg_advance;
   assign req_take     = req_valid && req_ready;
   assign stg_valid_in = req_take || (stg_valid_ff && !stg_advance);
   assign rsp_valid_in = (stg_advance && stg_end_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stg_advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_byte_ff <= req_host_byte;
         stg_has_ff  <= req_has_byte;
         stg_end_ff  <= req_end_of_host;
      end
      if (stg_advance && stg_end_ff) begin
         rsp_verdict_ff <= step_verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   `HNSC_ASSERT_NEXT(a_restart_after_end, stg_advance && stg_end_ff,
      state_ff == STATE_RESET, "state not restored after host end")
   `HNSC_ASSERT_NOW(a_underscore_le_count, 1'b1,
      state_ff.underscore_label <= state_ff.label_count,
      "underscore label beyond label count")
   `HNSC_ASSERT_NEXT(a_error_sticky, state_ff.found_error && !(stg_advance && stg_end_ff),
      state_ff.found_error, "error flag dropped before verdict")
   `HNSC_ASSERT_NEXT(a_end_blocked_hold, stg_valid_ff && stg_end_ff && !out_free,
      stg_valid_ff && stg_end_ff && $stable(state_ff), "blocked end request lost")

endmodule
